// ----- rtl/haversine_path_length_assert.svh -----
// Assertion macros shared by the checker of the haversine path length block.
// Depends on nothing; take it in with a plain include.
`ifndef HAVERSINE_PATH_LENGTH_ASSERT_SVH
`define HAVERSINE_PATH_LENGTH_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define HPL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("haversine path length: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define HPL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("haversine path length: next-cycle check failed");

`endif

// ----- rtl/hvpl_pkg.sv -----
// Types, constants and the arctangent table of the haversine path length block.
// Used by hvpl_cordic and haversine_path_length; depends on nothing.
`timescale 1ns / 1ps

package hvpl_pkg;

    localparam int CW = 36;   // CORDIC datapath width
    localparam int MW = 35;   // multiplier operand width

    typedef logic signed [CW-1:0] t_cval;
    typedef logic signed [MW-1:0] t_mop;

    typedef struct packed {
        logic start;
        logic vector_mode;    // 1: vectoring (atan2), 0: rotation (sine, cosine)
    } t_cordic_ctl;

    localparam t_cval GAIN_Q30   = 36'sd652032874;
    localparam t_mop  RAD_SCALE  = 35'sd2012227627;
    localparam t_mop  EARTH_R_CM = 35'sd637100000;

    // Full, half and quarter turn in 0.5e-7 degree (half angles) and 1e-7 degree.
    localparam t_cval TURN_HALF_ANG  = 36'sd7200000000;
    localparam t_cval HTURN_HALF_ANG = 36'sd3600000000;
    localparam t_cval QTURN_HALF_ANG = 36'sd1800000000;
    localparam t_cval TURN_FULL_ANG  = 36'sd3600000000;
    localparam t_cval HTURN_FULL_ANG = 36'sd1800000000;
    localparam t_cval QTURN_FULL_ANG = 36'sd900000000;

    localparam logic [60:0] ONE_Q60   = 61'd1 << 60;
    localparam logic [47:0] TOTAL_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] SEG_MAX   = 32'hFFFF_FFFF;

    // Truncated atan(2^-i) in Q2.30.
    function automatic t_cval atan_q30(input logic [5:0] i);
        t_cval v;
        v = '0;
        unique case (i)
            6'd0: v = 36'sd843314856;
            6'd1: v = 36'sd497837829;
            6'd2: v = 36'sd263043836;
            6'd3: v = 36'sd133525158;
            6'd4: v = 36'sd67021686;
            6'd5: v = 36'sd33543515;
            6'd6: v = 36'sd16775850;
            6'd7: v = 36'sd8388437;
            6'd8: v = 36'sd4194282;
            6'd9: v = 36'sd2097149;
            default: begin
                if (i < 6'd30) begin
                    v = (t_cval'(1) <<< (6'd30 - i)) - t_cval'(1);
                end else begin
                    v = '0;
                end
            end
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/hvpl_cordic.sv -----
// Shared CORDIC engine: rotation mode for sine and cosine, vectoring for atan2.
// Depends on hvpl_pkg.
`timescale 1ns / 1ps

module hvpl_cordic #(
    parameter int CORDIC_STEPS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  hvpl_pkg::t_cordic_ctl i_ctl,
    input  hvpl_pkg::t_cval      i_x,
    input  hvpl_pkg::t_cval      i_y,
    input  hvpl_pkg::t_cval      i_z,
    output hvpl_pkg::t_cval      o_x,
    output hvpl_pkg::t_cval      o_y,
    output hvpl_pkg::t_cval      o_z,
    output logic                 o_done
);

    localparam int IW = $clog2(CORDIC_STEPS);

    hvpl_pkg::t_cval r_x, r_y, r_z;
    hvpl_pkg::t_cval n_x, n_y, n_z;
    hvpl_pkg::t_cval w_sx, w_sy, w_at;
    logic [IW-1:0]   r_i;
    logic            r_busy, r_done, r_mode;

    always_comb begin
        w_sx = r_x >>> r_i;
        w_sy = r_y >>> r_i;
        w_at = hvpl_pkg::atan_q30(6'(r_i));
        if (r_mode ? !r_y[hvpl_pkg::CW-1] : r_z[hvpl_pkg::CW-1]) begin
            n_x = r_x + w_sy;
            n_y = r_y - w_sx;
            n_z = r_z + w_at;
        end else begin
            n_x = r_x - w_sy;
            n_y = r_y + w_sx;
            n_z = r_z - w_at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_mode <= i_ctl.vector_mode;
                r_x    <= i_x;
                r_y    <= i_y;
                r_z    <= i_z;
            end else if (r_busy) begin
                r_x <= n_x;
                r_y <= n_y;
                r_z <= n_z;
                r_i <= r_i + 1'b1;
                if (r_i == IW'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_done = r_done;

endmodule

// ----- rtl/hvpl_isqrt.sv -----
// Rounded integer square root of a 64-bit value, two bits of the input per step.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module hvpl_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_n,
    output logic [32:0] o_root,
    output logic        o_done
);

    logic [63:0] r_rem, r_res;
    logic [4:0]  r_k;
    logic        r_busy, r_rnd, r_done;
    logic [32:0] r_root;
    logic [5:0]  w_sh;
    logic [63:0] w_bit, w_trial;
    logic        w_ge;

    always_comb begin
        w_sh    = 6'd62 - {r_k, 1'b0};
        w_bit   = 64'd1 << w_sh;
        w_trial = r_res + w_bit;
        w_ge    = r_rem >= w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_rnd  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= '0;
                r_rem  <= i_n;
                r_res  <= '0;
            end else if (r_busy) begin
                if (w_ge) begin
                    r_rem <= r_rem - w_trial;
                    r_res <= (r_res >> 1) + w_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_k <= r_k + 5'd1;
                if (r_k == 5'd31) begin
                    r_busy <= 1'b0;
                    r_rnd  <= 1'b1;
                end
            end else if (r_rnd) begin
                // round to nearest: step up when the remainder exceeds the root
                r_rnd  <= 1'b0;
                r_done <= 1'b1;
                r_root <= r_res[32:0] + 33'(r_rem > r_res);
            end
        end
    end

    assign o_root = r_root;
    assign o_done = r_done;

endmodule

// ----- rtl/haversine_path_length.sv -----
// Haversine path length: top level with sequencer, shared multiplier and result register.
// Depends on hvpl_pkg, hvpl_cordic and hvpl_isqrt.
`timescale 1ns / 1ps

// Takes one waypoint per transaction and returns one result per waypoint. The first
// waypoint of a path (path_start set, or none stored since reset) gives no segment,
// a zero segment and a zero total. Every later waypoint is measured against the
// stored one: four sine/cosine passes and one atan2 pass of a single CORDIC unit,
// with angle reduction (wrap, fold, conversion to radians) before every sine/cosine
// pass, three passes of one rounded square root unit and eleven multiplier steps.
// Most of the time goes to the CORDIC and square root passes; s_axis_tready stays
// low while a waypoint is worked on. A finished result waits in the output register,
// so the next waypoint is taken while the previous result is still unread.
module haversine_path_length #(
    parameter int CORDIC_STEPS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,  // latitude[30:0], longitude[62:31], altitude[87:63]
    input  logic [0:0]  s_axis_tuser,  // path_start[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,  // segment_distance[31:0], path_total[79:32]
    output logic [0:0]  m_axis_tuser   // segment_valid[0]
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_WRAP, ST_FOLD, ST_CONV, ST_ZLOAD, ST_TRIG,
        ST_MCC, ST_RCC, ST_MU, ST_RU, ST_MS1, ST_RS1, ST_MA, ST_RA,
        ST_SQAGO, ST_SQA, ST_SQBGO, ST_SQB, ST_ATGO, ST_ATAN,
        ST_MSURF, ST_RSURF, ST_MSS, ST_RSS, ST_MDA, ST_RDA,
        ST_SQCGO, ST_SQC, ST_DONE
    } t_state;

    // Angle being reduced: half latitude and half longitude difference, then
    // the two latitudes.
    typedef enum logic [1:0] {A_DLAT, A_DLON, A_LAT1, A_LAT2} t_angle;

    t_state r_state;
    t_angle r_k;

    // current and stored waypoint
    logic signed [30:0] r_lat, r_prev_lat;
    logic signed [31:0] r_lon, r_prev_lon;
    logic signed [24:0] r_alt, r_prev_alt;
    logic               r_have;
    logic [47:0]        r_total;

    // working registers
    hvpl_pkg::t_cval    r_r;
    logic [30:0]        r_mag;
    logic               r_neg, r_flip;
    hvpl_pkg::t_mop     r_s1, r_s2, r_c1, r_c2, r_t;
    logic signed [63:0] r_prod, r_acc;
    logic [63:0]        r_sq;
    logic [60:0]        r_a60;
    logic [32:0]        r_ya, r_xa, r_ang;
    logic [31:0]        r_surf, r_seg;
    logic [25:0]        r_dalt;
    logic               r_segv;

    // output register
    logic               r_out_valid, r_out_segv;
    logic [31:0]        r_out_seg;
    logic [47:0]        r_out_total;

    // combinational
    hvpl_pkg::t_cval       w_v, w_turn, w_ht, w_q, w_wr, w_fold, w_z0;
    hvpl_pkg::t_cval       w_cx, w_cy, w_cz, w_cos;
    logic                  w_half, w_fflip, w_out_free, w_publish, n_out_valid;
    hvpl_pkg::t_mop        w_ma, w_mb, w_rnd30;
    logic signed [69:0]    w_full;
    logic signed [63:0]    n_prod, w_a;
    logic [63:0]           w_zsum, w_ssum, w_sq_n;
    logic [31:0]           w_zmag;
    logic [60:0]           w_aclamp;
    logic [25:0]           w_dalt;
    logic [48:0]           w_tsum;
    logic [47:0]           w_tnext;
    hvpl_pkg::t_cordic_ctl w_cctl;
    hvpl_pkg::t_cval       w_ox, w_oy, w_oz;
    logic                  w_cdone, w_sq_start, w_sq_done;
    logic [32:0]           w_root;
    logic [33:0]           w_ang2;

    always_comb begin
        // select the angle and its turn constants
        unique case (r_k)
            A_DLAT: w_v = hvpl_pkg::CW'(r_lat) - hvpl_pkg::CW'(r_prev_lat);
            A_DLON: w_v = hvpl_pkg::CW'(r_lon) - hvpl_pkg::CW'(r_prev_lon);
            A_LAT1: w_v = hvpl_pkg::CW'(r_prev_lat);
            A_LAT2: w_v = hvpl_pkg::CW'(r_lat);
            default: w_v = '0;
        endcase
        w_half = (r_k == A_DLAT) || (r_k == A_DLON);
        w_turn = w_half ? hvpl_pkg::TURN_HALF_ANG  : hvpl_pkg::TURN_FULL_ANG;
        w_ht   = w_half ? hvpl_pkg::HTURN_HALF_ANG : hvpl_pkg::HTURN_FULL_ANG;
        w_q    = w_half ? hvpl_pkg::QTURN_HALF_ANG : hvpl_pkg::QTURN_FULL_ANG;

        // wrap into (-half turn, half turn]; the value is always within one turn
        if (w_v > w_ht) begin
            w_wr = w_v - w_turn;
        end else if (w_v <= -w_ht) begin
            w_wr = w_v + w_turn;
        end else begin
            w_wr = w_v;
        end

        // fold into [-quarter, quarter], noting that the cosine flips
        if (r_r > w_q) begin
            w_fold  = w_ht - r_r;
            w_fflip = 1'b1;
        end else if (r_r < -w_q) begin
            w_fold  = -w_ht - r_r;
            w_fflip = 1'b1;
        end else begin
            w_fold  = r_r;
            w_fflip = 1'b0;
        end

        // degrees to Q2.30 radians, rounded; half angles take one more shift
        w_zsum = $unsigned(r_prod) + (w_half ? 64'd1 << 30 : 64'd1 << 29);
        w_zmag = w_half ? w_zsum[62:31] : w_zsum[61:30];
        w_z0   = r_neg ? -hvpl_pkg::CW'(w_zmag) : hvpl_pkg::CW'(w_zmag);

        // shared multiplier operands
        unique case (r_state)
            ST_CONV: begin
                w_ma = hvpl_pkg::MW'($signed({1'b0, r_mag}));
                w_mb = hvpl_pkg::RAD_SCALE;
            end
            ST_MCC: begin
                w_ma = r_c1;
                w_mb = r_c2;
            end
            ST_MU, ST_MA: begin
                w_ma = r_t;
                w_mb = r_s2;
            end
            ST_MS1: begin
                w_ma = r_s1;
                w_mb = r_s1;
            end
            ST_MSURF: begin
                w_ma = hvpl_pkg::MW'($signed({1'b0, r_ang}));
                w_mb = hvpl_pkg::EARTH_R_CM;
            end
            ST_MSS: begin
                w_ma = hvpl_pkg::MW'($signed({1'b0, r_surf}));
                w_mb = w_ma;
            end
            ST_MDA: begin
                w_ma = hvpl_pkg::MW'($signed({1'b0, r_dalt}));
                w_mb = w_ma;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
        w_full = w_ma * w_mb;
        n_prod = w_full[63:0];

        // Q60 product back to Q30, rounded half up
        w_rnd30 = hvpl_pkg::MW'((r_prod + 64'sd536870912) >>> 30);

        // haversine term clamped into [0, 1]
        w_a = r_acc + r_prod;
        if (w_a[63]) begin
            w_aclamp = '0;
        end else if (w_a > $signed({3'b0, hvpl_pkg::ONE_Q60})) begin
            w_aclamp = hvpl_pkg::ONE_Q60;
        end else begin
            w_aclamp = w_a[60:0];
        end

        w_ssum = $unsigned(r_prod) + (64'd1 << 29);
        w_dalt = (r_alt >= r_prev_alt) ? 26'(27'(r_alt) - 27'(r_prev_alt))
                                       : 26'(27'(r_prev_alt) - 27'(r_alt));

        // CORDIC launch
        w_cctl.start       = (r_state == ST_ZLOAD) || (r_state == ST_ATGO);
        w_cctl.vector_mode = (r_state == ST_ATGO);
        if (r_state == ST_ATGO) begin
            w_cx = hvpl_pkg::CW'(r_xa);
            w_cy = hvpl_pkg::CW'(r_ya);
            w_cz = '0;
        end else begin
            w_cx = hvpl_pkg::GAIN_Q30;
            w_cy = '0;
            w_cz = w_z0;
        end
        w_cos  = r_flip ? -w_ox : w_ox;
        w_ang2 = {w_oz[32:0], 1'b0};

        // square root launch
        w_sq_start = (r_state == ST_SQAGO) || (r_state == ST_SQBGO) || (r_state == ST_SQCGO);
        unique case (r_state)
            ST_SQAGO: w_sq_n = 64'(r_a60);
            ST_SQBGO: w_sq_n = 64'(hvpl_pkg::ONE_Q60 - r_a60);
            default:  w_sq_n = r_sq;
        endcase

        // saturating total
        w_tsum  = {1'b0, r_total} + 49'(r_seg);
        w_tnext = w_tsum[48] ? hvpl_pkg::TOTAL_MAX : w_tsum[47:0];

        // load a new result, else drop the held one once taken
        w_out_free  = !r_out_valid || m_axis_tready;
        w_publish   = (r_state == ST_DONE) && w_out_free;
        n_out_valid = w_publish || (r_out_valid && !m_axis_tready);
    end

    hvpl_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_cctl),
        .i_x    (w_cx),
        .i_y    (w_cy),
        .i_z    (w_cz),
        .o_x    (w_ox),
        .o_y    (w_oy),
        .o_z    (w_oz),
        .o_done (w_cdone)
    );

    hvpl_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_sq_start),
        .i_n    (w_sq_n),
        .o_root (w_root),
        .o_done (w_sq_done)
    );

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_k         <= A_DLAT;
            r_have      <= 1'b0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            r_prev_lat  <= '0;
            r_prev_lon  <= '0;
            r_prev_alt  <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_lat   <= s_axis_tdata[30:0];
                        r_lon   <= s_axis_tdata[62:31];
                        r_alt   <= s_axis_tdata[87:63];
                        r_k     <= A_DLAT;
                        if (s_axis_tuser[0] || !r_have) begin
                            r_segv  <= 1'b0;
                            r_seg   <= '0;
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= ST_WRAP;
                        end
                    end
                end
                ST_WRAP: begin
                    r_r     <= w_wr;
                    r_state <= ST_FOLD;
                end
                ST_FOLD: begin
                    r_neg   <= w_fold[hvpl_pkg::CW-1];
                    r_mag   <= 31'(w_fold[hvpl_pkg::CW-1] ? -w_fold : w_fold);
                    r_flip  <= w_fflip;
                    r_state <= ST_CONV;
                end
                ST_CONV:  r_state <= ST_ZLOAD;
                ST_ZLOAD: r_state <= ST_TRIG;
                ST_TRIG: begin
                    if (w_cdone) begin
                        unique case (r_k)
                            A_DLAT: r_s1 <= hvpl_pkg::MW'(w_oy);
                            A_DLON: r_s2 <= hvpl_pkg::MW'(w_oy);
                            A_LAT1: r_c1 <= hvpl_pkg::MW'(w_cos);
                            A_LAT2: r_c2 <= hvpl_pkg::MW'(w_cos);
                            default: r_c2 <= hvpl_pkg::MW'(w_cos);
                        endcase
                        if (r_k == A_LAT2) begin
                            r_state <= ST_MCC;
                        end else begin
                            r_k     <= t_angle'(r_k + 2'd1);
                            r_state <= ST_WRAP;
                        end
                    end
                end
                ST_MCC: r_state <= ST_RCC;
                ST_RCC: begin
                    r_t     <= w_rnd30;
                    r_state <= ST_MU;
                end
                ST_MU: r_state <= ST_RU;
                ST_RU: begin
                    r_t     <= w_rnd30;
                    r_state <= ST_MS1;
                end
                ST_MS1: r_state <= ST_RS1;
                ST_RS1: begin
                    r_acc   <= r_prod;
                    r_state <= ST_MA;
                end
                ST_MA: r_state <= ST_RA;
                ST_RA: begin
                    r_a60   <= w_aclamp;
                    r_state <= ST_SQAGO;
                end
                ST_SQAGO: r_state <= ST_SQA;
                ST_SQA: begin
                    if (w_sq_done) begin
                        r_ya    <= w_root;
                        r_state <= ST_SQBGO;
                    end
                end
                ST_SQBGO: r_state <= ST_SQB;
                ST_SQB: begin
                    if (w_sq_done) begin
                        r_xa    <= w_root;
                        r_state <= ST_ATGO;
                    end
                end
                ST_ATGO: r_state <= ST_ATAN;
                ST_ATAN: begin
                    if (w_cdone) begin
                        // central angle is twice the atan2, never negative
                        r_ang   <= w_oz[hvpl_pkg::CW-1] ? '0 : w_ang2[32:0];
                        r_state <= ST_MSURF;
                    end
                end
                ST_MSURF: r_state <= ST_RSURF;
                ST_RSURF: begin
                    r_surf  <= w_ssum[61:30];
                    r_dalt  <= w_dalt;
                    r_state <= ST_MSS;
                end
                ST_MSS: r_state <= ST_RSS;
                ST_RSS: begin
                    r_acc   <= r_prod;
                    r_state <= ST_MDA;
                end
                ST_MDA: r_state <= ST_RDA;
                ST_RDA: begin
                    r_sq    <= $unsigned(r_acc + r_prod);
                    r_state <= ST_SQCGO;
                end
                ST_SQCGO: r_state <= ST_SQC;
                ST_SQC: begin
                    if (w_sq_done) begin
                        r_seg   <= w_root[32] ? hvpl_pkg::SEG_MAX : w_root[31:0];
                        r_segv  <= 1'b1;
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // hold until the output register is free, then publish
                    if (w_out_free) begin
                        r_out_segv  <= r_segv;
                        r_out_seg   <= r_seg;
                        r_out_total <= r_segv ? w_tnext : '0;
                        r_total     <= r_segv ? w_tnext : '0;
                        r_prev_lat  <= r_lat;
                        r_prev_lon  <= r_lon;
                        r_prev_alt  <= r_alt;
                        r_have      <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_total, r_out_seg};
    assign m_axis_tuser  = r_out_segv;

endmodule

// ----- rtl/hvpl_checker.sv -----
// Port-level checks of the haversine path length block, bound to its top level.
// Depends on haversine_path_length_assert.svh.
`timescale 1ns / 1ps
`include "haversine_path_length_assert.svh"

module hvpl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [87:0] s_axis_tdata,
    input logic [0:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    // one waypoint at a time: ready drops after each transaction
    `HPL_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // no segment means zero segment and a cleared total
    `HPL_ASSERT_NOW(a_first_point_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[0], (m_axis_tdata[31:0] == 32'd0) && (m_axis_tdata[79:32] == 48'd0))

    // the total always covers the segment just added
    `HPL_ASSERT_NOW(a_total_covers_seg, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[79:32] >= 48'(m_axis_tdata[31:0]))

    // a stalled result holds
    `HPL_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind haversine_path_length hvpl_checker u_hvpl_checker (.*);

// ----- verif/haversine_path_length_checker.sv -----
// Scoreboard for haversine_path_length: watches both stream channels, predicts each result
// and compares it field by field. Depends on nothing but the ports of the block.
`timescale 1ns / 1ps

module haversine_path_length_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [87:0] i_in_data,   // latitude[30:0], longitude[62:31], altitude[87:63]
    input  logic [0:0]  i_in_user,   // path_start[0]
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [79:0] i_out_data,  // segment_distance[31:0], path_total[79:32]
    input  logic [0:0]  i_out_user,  // segment_valid[0]
    output int          o_fail_count,
    output int          o_pending
);

    localparam int STEPS = 32;
    localparam longint unsigned ONE_Q60 = 64'd1 << 60;
    localparam longint unsigned TOT_MAX = 64'hFFFF_FFFF_FFFF;

    typedef struct {
        logic        seg_valid;
        logic [31:0] seg_cm;
        logic [47:0] total_cm;
    } leg_t;

    leg_t leg_q[$];

    longint         prev_lat, prev_lon, prev_alt;
    bit             have_prev;
    longint unsigned path_cm;

    function automatic longint arc_step(int i);
        longint tbl[10] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                            33543515, 16775850, 8388437, 4194282, 2097149};
        if (i < 10) return tbl[i];
        if (i < 30) return (64'sd1 <<< (30 - i)) - 1;
        return 0;
    endfunction

    function automatic longint mul_q30(longint a, longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic longint unsigned root_rnd(longint unsigned n);
        longint unsigned rem, res, bt;
        rem = n;
        res = 0;
        bt  = 64'd1 << 62;
        while (bt > rem) bt >>= 2;
        while (bt != 0) begin
            if (rem >= res + bt) begin
                rem -= res + bt;
                res = (res >> 1) + bt;
            end else begin
                res >>= 1;
            end
            bt >>= 2;
        end
        if (rem > res) res++;
        return res;
    endfunction

    task automatic sin_cos(input longint v, input int half, output longint s,
                           output longint c);
        longint turn, hturn, qturn, r, x, y, z, dx, dy;
        longint unsigned m, ang;
        bit flip;
        turn  = 64'sd3600000000 <<< half;
        hturn = turn / 2;
        qturn = turn / 4;
        r     = v % turn;
        flip  = 0;
        if (r > hturn) r -= turn;
        else if (r <= -hturn) r += turn;
        if (r > qturn) begin
            r = hturn - r;
            flip = 1;
        end else if (r < -qturn) begin
            r = -hturn - r;
            flip = 1;
        end
        m   = (r < 0) ? -r : r;
        ang = (m * 64'd2012227627 + (64'd1 << (29 + half))) >> (30 + half);
        z   = (r < 0) ? -longint'(ang) : longint'(ang);
        x   = 652032874;
        y   = 0;
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= arc_step(i);
            end else begin
                x += dx; y -= dy; z += arc_step(i);
            end
        end
        s = y;
        c = flip ? -x : x;
    endtask

    function automatic longint central_atan(longint y, longint x);
        longint z, dx, dy;
        z = 0;
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += arc_step(i);
            end else begin
                x -= dx; y += dy; z -= arc_step(i);
            end
        end
        return z;
    endfunction

    task automatic leg_length(input longint la1, lo1, al1, la2, lo2, al2,
                              output longint unsigned seg);
        longint s1, k1, s2, k2, sp, c1, sl, c2, cc, u, a, ang;
        longint unsigned a60, ya, xa, surf, dalt;
        sin_cos(la2 - la1, 1, s1, k1);
        sin_cos(lo2 - lo1, 1, s2, k2);
        sin_cos(la1, 0, sp, c1);
        sin_cos(la2, 0, sl, c2);
        cc = mul_q30(c1, c2);
        u  = mul_q30(cc, s2);
        a  = s1 * s1 + u * s2;
        if (a < 0) a = 0;
        a60 = a;
        if (a60 > ONE_Q60) a60 = ONE_Q60;
        ya  = root_rnd(a60);
        xa  = root_rnd(ONE_Q60 - a60);
        ang = 2 * central_atan(longint'(ya), longint'(xa));
        if (ang < 0) ang = 0;
        surf = (longint'(ang) * 64'd637100000 + (64'd1 << 29)) >> 30;
        dalt = (al2 >= al1) ? al2 - al1 : al1 - al2;
        seg  = root_rnd(surf * surf + dalt * dalt);
        if (seg > 64'hFFFF_FFFF) seg = 64'hFFFF_FFFF;
    endtask

    assign o_pending = leg_q.size();

    always @(posedge i_clk) begin
        longint lat, lon, alt;
        longint unsigned seg;
        leg_t e, got;
        if (!i_rst_n) begin
            prev_lat = 0; prev_lon = 0; prev_alt = 0;
            have_prev = 0;
            path_cm = 0;
            leg_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                lat = longint'($signed(i_in_data[30:0]));
                lon = longint'($signed(i_in_data[62:31]));
                alt = longint'($signed(i_in_data[87:63]));
                e.seg_valid = 0;
                seg = 0;
                if (i_in_user[0] || !have_prev) begin
                    path_cm = 0;
                end else begin
                    leg_length(prev_lat, prev_lon, prev_alt, lat, lon, alt, seg);
                    e.seg_valid = 1;
                    path_cm += seg;
                    if (path_cm > TOT_MAX) path_cm = TOT_MAX;
                end
                e.seg_cm   = seg[31:0];
                e.total_cm = path_cm[47:0];
                prev_lat = lat; prev_lon = lon; prev_alt = alt;
                have_prev = 1;
                leg_q.insert(leg_q.size(), e);
            end
            if (i_out_valid && i_out_ready) begin
                got.seg_valid = i_out_user[0];
                got.seg_cm    = i_out_data[31:0];
                got.total_cm  = i_out_data[79:32];
                if (leg_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result: valid %0d seg %0d total %0d",
                                 got.seg_valid, got.seg_cm, got.total_cm);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = leg_q.pop_front();
                    if (e.seg_valid !== got.seg_valid || e.seg_cm !== got.seg_cm ||
                        e.total_cm !== got.total_cm) begin
                        if (o_fail_count < 10)
                            $display("mismatch: exp valid %0d seg %0d total %0d, got %0d %0d %0d",
                                     e.seg_valid, e.seg_cm, e.total_cm,
                                     got.seg_valid, got.seg_cm, got.total_cm);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ----- verif/haversine_path_length_tb.sv -----
// Top of the haversine_path_length regression: clock, reset, waypoint stimulus and verdict.
// Depends on haversine_path_length and haversine_path_length_checker.
`timescale 1ns / 1ps

module haversine_path_length_tb;

    localparam int  N_ITEMS   = 750;
    localparam int  CYC_LIMIT = 3000000;
    localparam int  HOLD_CYC  = 3000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata;   // latitude[30:0], longitude[62:31], altitude[87:63]
    logic [0:0]  s_axis_tuser;   // path_start[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;   // segment_distance[31:0], path_total[79:32]
    logic [0:0]  m_axis_tuser;   // segment_valid[0]

    int  fail_count;
    int  pending;
    bit  idle_en;     // random gaps on both sides
    bit  hold_req;    // ask the receiver for one long hold-off
    int  cycles;
    int  sent;

    // Current position of the random walk.
    longint walk_lat, walk_lon, walk_alt;

    haversine_path_length DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    haversine_path_length_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_user    (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_user   (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Abort on a hang: count every cycle from the start.
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYC_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Receiver: random bursts of back-pressure, plus one long hold-off on request.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYC - 1) @(negedge i_clk);
                hold_req = 0;
            end else if (idle_en && $urandom_range(0, 9) < 2) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 18) - 1) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Offer one waypoint and hold it until the block takes it. Valid stays high into the
    // next transaction unless a gap is drawn.
    task automatic send_point(input longint lat, input longint lon, input longint alt,
                              input bit first);
        int gap;
        if (idle_en && $urandom_range(0, 9) < 3) begin
            gap = $urandom_range(1, 18);
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {alt[24:0], lon[31:0], lat[30:0]};
        s_axis_tuser  <= first;
        do @(posedge i_clk); while (!s_axis_tready);
        sent++;
    endtask

    // Advance the walk by a small or moderate random step, kept inside the legal ranges.
    task automatic walk_step(input longint span);
        walk_lat += longint'($urandom_range(0, 2 * span)) - span;
        walk_lon += longint'($urandom_range(0, 4 * span)) - 2 * span;
        walk_alt += longint'($urandom_range(0, 20000)) - 10000;
        if (walk_lat > 900000000)  walk_lat = 900000000;
        if (walk_lat < -900000000) walk_lat = -900000000;
        if (walk_lon > 1800000000)  walk_lon = walk_lon - 64'sd3600000000;
        if (walk_lon < -1800000000) walk_lon = walk_lon + 64'sd3600000000;
        if (walk_alt > 10000000) walk_alt = 10000000;
        if (walk_alt < -100000)  walk_alt = -100000;
    endtask

    initial begin
        int len;
        longint span;
        bit held, paused;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        idle_en  = 1;
        hold_req = 0;
        sent     = 0;
        held     = 0;
        paused   = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: no stored point after reset with the start flag clear, then zero
        // movement, range extremes, wrapped and folded angles, altitude extremes.
        send_point(0, 0, 0, 0);
        send_point(0, 0, 0, 0);
        send_point(900000000, 1800000000, 10000000, 0);
        send_point(-900000000, -1800000000, -100000, 0);
        send_point(900000000, 0, 0, 1);
        send_point(-900000000, 1800000000, 10000000, 0);
        send_point(0, -1800000000, -100000, 0);
        send_point(0, 1800000000, -100000, 0);
        send_point(1073741823, 2147483647, 16777215, 0);
        send_point(-1073741824, -2147483648, -16777216, 0);
        send_point(1073741823, -2147483648, 16777215, 0);
        send_point(-1073741824, 2147483647, -16777216, 0);
        send_point(450000000, 900000000, 5000, 1);
        send_point(450000001, 900000001, 5001, 0);
        send_point(-450000000, -900000000, 5001, 0);
        send_point(0, 0, 10000000, 0);
        send_point(0, 0, -100000, 0);
        send_point(899999999, 1799999999, 0, 0);
        send_point(-899999999, 1799999999, 0, 0);
        send_point(0, 0, 0, 1);

        // Random paths: mostly well-formed walks, some wild full-width points.
        while (sent < N_ITEMS) begin
            if (!held && sent > 300) begin
                hold_req = 1;
                held = 1;
            end
            if (!paused && sent > 480) begin
                // withdraw the offer, then wait for every result to come back
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                wait (pending == 0);
                paused = 1;
            end
            if (sent > 650) idle_en = 0;
            walk_lat = longint'($urandom_range(0, 1800000000)) - 900000000;
            walk_lon = longint'($urandom_range(0, 3600000000)) - 1800000000;
            walk_alt = longint'($urandom_range(0, 10100000)) - 100000;
            send_point(walk_lat, walk_lon, walk_alt, $urandom_range(0, 9) != 0);
            len = $urandom_range(2, 16);
            span = ($urandom_range(0, 3) == 0) ? 200000000 : 200000;
            for (int k = 0; k < len && sent < N_ITEMS; k++) begin
                if ($urandom_range(0, 19) == 0) begin
                    send_point(longint'($signed({$urandom} & 32'h7FFF_FFFF)),
                               longint'($signed($urandom)),
                               longint'($signed($urandom)), $urandom_range(0, 1));
                end else begin
                    walk_step(span);
                    send_point(walk_lat, walk_lon, walk_alt, 0);
                end
            end
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;

        // Drain, then let the block settle.
        wait (pending == 0);
        repeat (400) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
